FILE: sv/bpc_pkg.sv
package bpc_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int TAG_BITS    = 16;
   localparam int PTR_BITS    = $clog2(STACK_DEPTH);
   localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
   localparam int KIND_BITS   = 4;
   localparam int STATUS_BITS = 4;
   localparam int CODE_BITS   = 3;

   // item queue between front and back, depth is a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_OPEN_BRACE   = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_CLOSE_BRACE  = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_OPEN_PAREN   = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_CLOSE_PAREN  = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_OPEN_SQUARE  = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_CLOSE_SQUARE = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_OPEN_ANGLE   = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_CLOSE_ANGLE  = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_MARKER       = 4'd9;

   // stack entry codes: 1..4 are the openers, then the marker
   localparam logic [CODE_BITS-1:0] CODE_MARKER = 3'd5;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_OK            = 4'd0;
   localparam logic [STATUS_BITS-1:0] ST_CLOSE_OFFSET  = 4'd4;
   localparam logic [STATUS_BITS-1:0] ST_INVALID_CLOSE = 4'd9;
   localparam logic [STATUS_BITS-1:0] ST_UNCLOSED      = 4'd10;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW      = 4'd11;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_OPEN,
      OP_CLOSE,
      OP_MARK
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [CODE_BITS-1:0]  code;
      logic [TAG_BITS-1:0]   tag;
      logic                  last;
   } item_type;

endpackage

FILE: sv/bpc_front.sv
module bpc_front
   import bpc_pkg::*;
(
   input  logic [KIND_BITS-1:0] token_kind,
   input  logic [TAG_BITS-1:0]  token_tag,
   input  logic                 last_token,
   output item_type             item
);

   // map a token kind onto a stack operation and its opener code
   always_comb begin
      item.tag  = token_tag;
      item.last = last_token;
      item.op   = OP_NONE;
      item.code = '0;
      unique case (token_kind) inside
         KIND_OPEN_BRACE, KIND_OPEN_PAREN, KIND_OPEN_SQUARE, KIND_OPEN_ANGLE: begin
            item.op   = OP_OPEN;
            item.code = CODE_BITS'((token_kind + 4'd1) >> 1);
         end
         KIND_CLOSE_BRACE, KIND_CLOSE_PAREN, KIND_CLOSE_SQUARE, KIND_CLOSE_ANGLE: begin
            item.op   = OP_CLOSE;
            item.code = CODE_BITS'(token_kind >> 1);
         end
         KIND_MARKER: begin
            item.op   = OP_MARK;
            item.code = CODE_MARKER;
         end
         default: ;
      endcase
   end

endmodule

FILE: sv/bpc_queue.sv
module bpc_queue
   import bpc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type head
);

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(do_push);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(do_pop);
      count_in  = count_ff + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/bpc_back.sv
module bpc_back
   import bpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  item_type               q_head,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [TAG_BITS-1:0]    rsp_error_tag
);

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   // every entry below the top; the one just below the top is also cached in below_ff
   entry_type stack_mem [STACK_DEPTH];

   entry_type               top_ff, top_in;
   entry_type               below_ff;
   logic [CNT_BITS-1:0]     count_ff, count_in, cnt_next, cnt_m1, cnt_m3;
   logic                    err_ff, err_in, err_next;
   logic [STATUS_BITS-1:0]  hstat_ff, hstat_in, hstat_next;
   logic [TAG_BITS-1:0]     htag_ff, htag_in, htag_next;
   logic                    rvalid_ff, rvalid_in;
   logic [STATUS_BITS-1:0]  rstat_ff, rstat_in;
   logic [TAG_BITS-1:0]     rtag_ff, rtag_in;

   logic                    slot_free, take, finish;
   logic                    want_push, do_push, do_pop, new_err, mem_we;
   logic [STATUS_BITS-1:0]  new_stat;
   logic [PTR_BITS-1:0]     wr_addr, rd_addr;

   assign rsp_empty     = !rvalid_ff;
   assign rsp_status    = rstat_ff;
   assign rsp_error_tag = rtag_ff;
   assign q_pop         = take;

   always_comb begin
      slot_free = !rvalid_ff || rsp_pop;
      take      = q_valid && (!q_head.last || slot_free);
      finish    = take && q_head.last;

      want_push = 1'b0;
      do_pop    = 1'b0;
      new_err   = 1'b0;
      new_stat  = ST_OK;
      if (take && !err_ff) begin
         unique case (q_head.op)
            OP_OPEN: want_push = 1'b1;
            OP_MARK: begin
               if (count_ff != '0 && top_ff.code == CODE_MARKER) begin
                  do_pop = 1'b1;
               end else begin
                  want_push = 1'b1;
               end
            end
            OP_CLOSE: begin
               if (count_ff == '0) begin
                  new_err  = 1'b1;
                  new_stat = STATUS_BITS'(q_head.code);
               end else if (top_ff.code == q_head.code) begin
                  do_pop = 1'b1;
               end else if (top_ff.code != CODE_MARKER) begin
                  new_err  = 1'b1;
                  new_stat = STATUS_BITS'(top_ff.code) + ST_CLOSE_OFFSET;
               end else begin
                  new_err  = 1'b1;
                  new_stat = ST_INVALID_CLOSE;
               end
            end
            default: ;
         endcase
      end

      do_push = 1'b0;
      if (want_push) begin
         if (count_ff == CNT_BITS'(STACK_DEPTH)) begin
            new_err  = 1'b1;
            new_stat = ST_OVERFLOW;
         end else begin
            do_push = 1'b1;
         end
      end

      cnt_m1  = count_ff - CNT_BITS'(1);
      cnt_m3  = count_ff - CNT_BITS'(3);
      wr_addr = cnt_m1[PTR_BITS-1:0];
      rd_addr = cnt_m3[PTR_BITS-1:0];
      mem_we  = do_push && (count_ff != '0);

      cnt_next = count_ff + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
      if (do_push) begin
         top_in = '{code: q_head.code, tag: q_head.tag};
      end else if (do_pop) begin
         top_in = below_ff;
      end else begin
         top_in = top_ff;
      end
      err_next   = err_ff || new_err;
      hstat_next = new_err ? new_stat : hstat_ff;
      htag_next  = new_err ? q_head.tag : htag_ff;

      // outcome of the stream on its last item
      if (err_next) begin
         rstat_in = hstat_next;
         rtag_in  = htag_next;
      end else if (cnt_next != '0) begin
         rstat_in = ST_UNCLOSED;
         rtag_in  = top_in.tag;
      end else begin
         rstat_in = ST_OK;
         rtag_in  = '0;
      end

      count_in  = finish ? '0 : cnt_next;
      err_in    = finish ? 1'b0 : err_next;
      hstat_in  = finish ? ST_OK : hstat_next;
      htag_in   = finish ? '0 : htag_next;
      rvalid_in = finish ? 1'b1 : (rvalid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         err_ff    <= 1'b0;
         hstat_ff  <= ST_OK;
         htag_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         err_ff    <= err_in;
         hstat_ff  <= hstat_in;
         htag_ff   <= htag_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (finish) begin
         rstat_ff <= rstat_in;
         rtag_ff  <= rtag_in;
      end
   end

   // stack memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= top_ff;
      end
      if (do_push) begin
         below_ff <= top_ff;
      end else if (do_pop) begin
         below_ff <= stack_mem[rd_addr];
      end
   end

endmodule

FILE: sv/bracket_pair_checker.sv
// path: an accepted item is written into the item queue, taken from its head by the stack engine,
//    and for a last item the result is registered onto the rsp_ ports
// throughput: one item per cycle unless stalled, set by the stack update (top and next
//    entries cached in registers, one write and one read of the stack memory per cycle);
//    a last item stalls while an earlier result waits unpopped, four queued items raise req_full
// reset: clears the item queue, stack count, error flag and waiting result, not the stack memory
module bracket_pair_checker
   import bpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input item channel
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [KIND_BITS-1:0]   req_token_kind,
   input  logic [TAG_BITS-1:0]    req_token_tag,
   input  logic                   req_last_token,
   // result channel
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [TAG_BITS-1:0]    rsp_error_tag
);

   // classified item from the front
   item_type front_item;
   // head of the item queue as seen by the stack engine
   item_type q_head;
   logic     q_valid;
   logic     q_pop;

   // front: decode token kind into push, close, marker or nothing
   bpc_front u_front (
      .token_kind (req_token_kind),
      .token_tag  (req_token_tag),
      .last_token (req_last_token),
      .item       (front_item)
   );

   // short queue so the front keeps taking items while the back waits on rsp_pop
   bpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .full      (req_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   // back: stack engine, error hold and result register
   // a last item waits in the queue only while an untaken result blocks it
   bpc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_status    (rsp_status),
      .rsp_error_tag (rsp_error_tag)
   );

   // a result appears only after the back took a last item
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(q_pop && q_head.last))
      else $error("result appeared without a last item");

   // a last item never overwrites a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.last) |-> (rsp_empty || rsp_pop))
      else $error("last item taken while result slot busy");

   // the back only pops a queue that holds an item
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // a full queue always offers an item to the back
   assert property (@(posedge clock) disable iff (reset)
      req_full |-> q_valid)
      else $error("queue full but head not valid");

endmodule

FILE: test/tb_bracket_pair_checker.sv
module tb_bracket_pair_checker;
   import bpc_pkg::*;

   // run length and limits
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 750;
   localparam int DRAIN_CYCLES = 8;
   localparam int NEST_LIMIT   = 8;

   // kinds the block skips over
   localparam logic [KIND_BITS-1:0] KIND_OTHER      = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_UNUSED_MIN = 4'd10;
   localparam logic [KIND_BITS-1:0] KIND_UNUSED_MAX = 4'd15;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [TAG_BITS-1:0]    tag;
   } verdict_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [TAG_BITS-1:0]  tag;
      logic                 is_last;
   } token_type;

   // bracket pairing predictor plus the queue of verdicts still owed by the block
   class pairing_scoreboard;
      logic [CODE_BITS-1:0] open_code [STACK_DEPTH];
      logic [TAG_BITS-1:0]  open_tag  [STACK_DEPTH];
      int                   depth;
      bit                   error_held;
      verdict_type          held;
      verdict_type          pending_verdicts[$];
      int                   mismatches;

      function new();
         depth      = 0;
         error_held = 1'b0;
         held       = '0;
         mismatches = 0;
      endfunction

      function void hold_error(logic [STATUS_BITS-1:0] status, logic [TAG_BITS-1:0] tag);
         error_held  = 1'b1;
         held.status = status;
         held.tag    = tag;
      endfunction

      function void push_opener(logic [CODE_BITS-1:0] code, logic [TAG_BITS-1:0] tag);
         if (depth >= STACK_DEPTH) begin
            hold_error(ST_OVERFLOW, tag);
         end else begin
            open_code[depth] = code;
            open_tag[depth]  = tag;
            depth++;
         end
      endfunction

      function void apply_token(logic [KIND_BITS-1:0] kind, logic [TAG_BITS-1:0] tag);
         logic [CODE_BITS-1:0] pair_code;
         if (kind == KIND_MARKER) begin
            if (depth > 0 && open_code[depth-1] == CODE_MARKER)
               depth--;
            else
               push_opener(CODE_MARKER, tag);
         end else if (kind >= KIND_OPEN_BRACE && kind <= KIND_CLOSE_ANGLE) begin
            pair_code = CODE_BITS'((kind + 1) >> 1);
            if (kind[0])
               push_opener(pair_code, tag);
            else if (depth == 0)
               hold_error(STATUS_BITS'(pair_code), tag);
            else if (open_code[depth-1] == pair_code)
               depth--;
            else if (open_code[depth-1] == CODE_MARKER)
               hold_error(ST_INVALID_CLOSE, tag);
            else
               hold_error(ST_CLOSE_OFFSET + STATUS_BITS'(open_code[depth-1]), tag);
         end
      endfunction

      function void note_token(token_type t);
         verdict_type clean;
         clean = '0;
         if (!error_held)
            apply_token(t.kind, t.tag);
         if (t.is_last) begin
            if (!error_held && depth > 0)
               hold_error(ST_UNCLOSED, open_tag[depth-1]);
            pending_verdicts.insert(pending_verdicts.size(), error_held ? held : clean);
            depth      = 0;
            error_held = 1'b0;
            held       = '0;
         end
      endfunction

      function void check_result(logic [STATUS_BITS-1:0] status, logic [TAG_BITS-1:0] tag);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $error("result with no item waiting: status %0d, error_tag %0h", status, tag);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            if (status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, status);
               mismatches++;
            end
            if (tag !== want.tag) begin
               $error("error_tag: expected %0h, actual %0h", want.tag, tag);
               mismatches++;
            end
         end
      endfunction
   endclass

   // clock, reset and the block's ports; the driven inputs are known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [KIND_BITS-1:0]   req_token_kind = '0;
   logic [TAG_BITS-1:0]    req_token_tag = '0;
   logic                   req_last_token = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [TAG_BITS-1:0]    rsp_error_tag;

   pairing_scoreboard sb = new();

   token_type stream_q[$];
   int        items_sent    = 0;
   int        send_idle_pct = 38;
   int        recv_idle_pct = 51;
   int        cycle_count   = 0;

   bracket_pair_checker dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_token_kind (req_token_kind),
      .req_token_tag  (req_token_tag),
      .req_last_token (req_last_token),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_error_tag  (rsp_error_tag)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // run guard: a lost result or a stuck handshake ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: check what was popped at this edge, then pick the next pop
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_result(rsp_status, rsp_error_tag);
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // idle mix moves with progress: receiver-heavy gaps, then sender-heavy, then none
   function automatic void update_idle_mix();
      if (items_sent < RANDOM_ITEMS / 3) begin
         send_idle_pct = 38;
         recv_idle_pct = 51;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
         send_idle_pct = 51;
         recv_idle_pct = 38;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endfunction

   // one item: random gap, then hold push until the block takes it
   task automatic send_token(token_type t);
      update_idle_mix();
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_token_kind <= t.kind;
      req_token_tag  <= t.tag;
      req_last_token <= t.is_last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_token(t);
   endtask

   task automatic play_stream();
      foreach (stream_q[n]) begin
         send_token(stream_q[n]);
         items_sent++;
      end
      stream_q.delete();
   endtask

   function automatic void add_fixed(logic [KIND_BITS-1:0] kind, logic [TAG_BITS-1:0] tag,
                                     logic is_last);
      token_type t;
      t.kind    = kind;
      t.tag     = tag;
      t.is_last = is_last;
      stream_q.insert(stream_q.size(), t);
   endfunction

   function automatic void add_token(logic [KIND_BITS-1:0] kind);
      add_fixed(kind, TAG_BITS'($urandom), 1'b0);
   endfunction

   function automatic logic [KIND_BITS-1:0] skip_kind();
      if ($urandom_range(1))
         return KIND_OTHER;
      return KIND_BITS'($urandom_range(KIND_UNUSED_MIN, KIND_UNUSED_MAX));
   endfunction

   // well-formed nesting with random content; close_all = 0 leaves openers hanging
   function automatic void build_nested(int len, bit close_all);
      int open_kinds[$];
      int r;
      int k;
      for (int n = 0; n < len; n++) begin
         r = $urandom_range(9);
         if (r <= 3 && open_kinds.size() < NEST_LIMIT) begin
            k = 2 * $urandom_range(3) + 1;
            open_kinds.insert(open_kinds.size(), k);
            add_token(KIND_BITS'(k));
         end else if (r <= 6 && open_kinds.size() > 0) begin
            k = open_kinds[$];
            open_kinds.delete(open_kinds.size() - 1);
            add_token(k == KIND_MARKER ? KIND_MARKER : KIND_BITS'(k + 1));
         end else if (r == 7) begin
            add_token(skip_kind());
         end else if (open_kinds.size() > 0 && open_kinds[$] == KIND_MARKER) begin
            // marker on marker closes the description block
            open_kinds.delete(open_kinds.size() - 1);
            add_token(KIND_MARKER);
         end else if (open_kinds.size() < NEST_LIMIT) begin
            open_kinds.insert(open_kinds.size(), int'(KIND_MARKER));
            add_token(KIND_MARKER);
         end else begin
            add_token(skip_kind());
         end
      end
      while (close_all && open_kinds.size() > 0) begin
         k = open_kinds[$];
         open_kinds.delete(open_kinds.size() - 1);
         add_token(k == KIND_MARKER ? KIND_MARKER : KIND_BITS'(k + 1));
      end
   endfunction

   // deep nesting up to and past the stack size, then closed in order
   function automatic void build_deep(int pushes);
      int open_kinds[$];
      int k;
      for (int n = 0; n < pushes; n++) begin
         // markers never back to back, so each one opens a new level
         k = (n % 5 == 4) ? int'(KIND_MARKER) : 2 * $urandom_range(3) + 1;
         open_kinds.insert(open_kinds.size(), k);
         add_token(KIND_BITS'(k));
      end
      while (open_kinds.size() > 0) begin
         k = open_kinds[$];
         open_kinds.delete(open_kinds.size() - 1);
         add_token(k == KIND_MARKER ? KIND_MARKER : KIND_BITS'(k + 1));
      end
   endfunction

   // random kinds everywhere, last marks scattered through
   function automatic void build_noise(int len);
      for (int n = 0; n < len; n++) begin
         add_token(KIND_BITS'($urandom_range(KIND_UNUSED_MAX)));
         stream_q[$].is_last = ($urandom_range(7) == 0);
      end
   endfunction

   initial begin
      int stream_no;
      int mode;
      stream_no = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // all four pairs nested, last mark on the outer closer
      add_fixed(KIND_OPEN_BRACE,   16'h0000, 1'b0);
      add_fixed(KIND_OPEN_PAREN,   16'hFFFF, 1'b0);
      add_fixed(KIND_OPEN_SQUARE,  16'h5A5A, 1'b0);
      add_fixed(KIND_OPEN_ANGLE,   16'hA5A5, 1'b0);
      add_fixed(KIND_CLOSE_ANGLE,  16'h0001, 1'b0);
      add_fixed(KIND_CLOSE_SQUARE, 16'h8000, 1'b0);
      add_fixed(KIND_CLOSE_PAREN,  16'h7FFF, 1'b0);
      add_fixed(KIND_CLOSE_BRACE,  16'hFFFE, 1'b1);
      // closer with nothing open
      add_fixed(KIND_CLOSE_SQUARE, 16'hFFFF, 1'b1);
      // marker pair cancels out
      add_fixed(KIND_MARKER, 16'h1234, 1'b0);
      add_fixed(KIND_MARKER, 16'h4321, 1'b1);
      // closer against a marker, unused kind skipped, error raised on the last item
      add_fixed(KIND_OPEN_PAREN,  16'h0F0F, 1'b0);
      add_fixed(KIND_UNUSED_MAX,  16'h1111, 1'b0);
      add_fixed(KIND_MARKER,      16'h2222, 1'b0);
      add_fixed(KIND_CLOSE_PAREN, 16'hBEEF, 1'b1);
      // wrong closer, later tokens ignored
      add_fixed(KIND_OPEN_ANGLE,  16'h3333, 1'b0);
      add_fixed(KIND_CLOSE_BRACE, 16'h4444, 1'b0);
      add_fixed(KIND_CLOSE_ANGLE, 16'h5555, 1'b1);
      // unclosed, reported with the top opener's tag
      add_fixed(KIND_OPEN_SQUARE, 16'h0123, 1'b0);
      add_fixed(KIND_OPEN_BRACE,  16'hFEDC, 1'b0);
      add_fixed(KIND_OTHER,       16'h6666, 1'b1);
      play_stream();

      // random streams: mostly well-formed, some broken, a little noise
      while (items_sent < RANDOM_ITEMS) begin
         if (stream_no == 0) begin
            build_deep(STACK_DEPTH + 1 + $urandom_range(2));
         end else if (stream_no == 1) begin
            build_deep(STACK_DEPTH);
         end else begin
            mode = $urandom_range(99);
            if (mode < 55) begin
               build_nested($urandom_range(1, 16), 1'b1);
            end else if (mode < 70) begin
               build_nested($urandom_range(1, 16), 1'b1);
               stream_q[$urandom_range(stream_q.size() - 1)].kind =
                  KIND_BITS'($urandom_range(KIND_OPEN_BRACE, KIND_MARKER));
            end else if (mode < 82) begin
               build_nested($urandom_range(1, 16), 1'b0);
            end else if (mode < 83) begin
               build_deep($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3));
            end else begin
               build_noise($urandom_range(1, 10));
            end
         end
         if (stream_q.size() == 0)
            add_token(skip_kind());
         stream_q[$].is_last = 1'b1;
         play_stream();
         stream_no++;
      end
      req_push <= 1'b0;

      // wait for every owed verdict, then a short quiet stretch
      while (sb.pending_verdicts.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
